@@ sv/b32c_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_pkg
// shared types, constants and the polymod step of the bech32 checksum engine
// ----------------------------------------------------------------------------
package b32c_pkg;

    localparam int PREFIX_DEPTH = 128;
    localparam int CNT_W        = $clog2(PREFIX_DEPTH + 1);
    localparam int ADDR_W       = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
    localparam int RES_W        = 30;
    localparam int SYM_W        = 5;
    localparam int VAL_W        = 7;
    localparam int OPC_W        = 2;
    localparam int NUM_SYMS     = 6;
    localparam int BEAT_W       = 3;

    typedef logic [OPC_W-1:0] t_opcode;
    typedef logic [VAL_W-1:0] t_value;
    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [RES_W-1:0] t_res;
    typedef logic             t_reg_idx;

    localparam t_opcode OP_PREFIX = 2'd0;
    localparam t_opcode OP_DATA   = 2'd1;
    localparam t_opcode OP_FINISH = 2'd2;

    localparam t_reg_idx REG_USE_BECH32M = 1'b0;
    localparam t_reg_idx REG_VERIFY_MODE = 1'b1;

    localparam t_res BECH32_FINAL  = 30'h0000_0001;
    localparam t_res BECH32M_FINAL = 30'h2bc8_30a3;
    localparam logic [24:0] LOW25_MASK = 25'h1ff_ffff;

    localparam t_res GEN_TABLE [0:4] = '{
        30'h3b6a_57b2, 30'h2650_8e6d, 30'h1ea1_19fa, 30'h3d42_33dd, 30'h2a14_62b3
    };

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(NUM_SYMS - 1);

    typedef enum logic [2:0] {
        FEED_ZERO,
        FEED_IN_HI,
        FEED_IN_LO,
        FEED_WALK,
        FEED_PEND_LO
    } t_feed_sel;

    typedef struct packed {
        logic      feed_en;
        t_feed_sel feed_sel;
        logic      store_en;
        logic      pend_latch;
        logic      walk_clr;
        logic      walk_step;
        logic      phase_set;
        logic      chk_load;
        logic      ver_load;
        logic      chk_shift;
        logic      restart;
    } t_cmd;

    typedef struct packed {
        logic data_phase;
        logic walk_done;
        logic pend_finish;
        logic verify_mode;
    } t_sts;

    function automatic t_res poly_step(input t_res res, input t_sym sym);
        t_res        acc;
        logic [4:0]  top;
        top = res[RES_W-1:25];
        acc = {res[24:0] & LOW25_MASK, sym};
        for (int k = 0; k < 5; k++) begin
            if (top[k]) begin
                acc = acc ^ GEN_TABLE[k];
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

@@ sv/b32c_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_in_if
// input item channel: opcode and value with valid/ready
// ----------------------------------------------------------------------------
interface b32c_in_if;
    import b32c_pkg::*;
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_value  value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

@@ sv/b32c_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_out_if
// result channel: checksum symbol, verify flag, overflow flag and last
// ----------------------------------------------------------------------------
interface b32c_out_if;
    import b32c_pkg::*;
    logic valid;
    logic ready;
    t_sym symbol;
    logic valid_res;
    logic prefix_overflow;
    logic last;
    modport source (output valid, output symbol, output valid_res,
                    output prefix_overflow, output last, input ready);
    modport sink   (input valid, input symbol, input valid_res,
                    input prefix_overflow, input last, output ready);
endinterface
`default_nettype wire

@@ sv/b32c_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_cfg_if
// configuration write channel: register index and data with valid/ready
// ----------------------------------------------------------------------------
interface b32c_cfg_if;
    import b32c_pkg::*;
    logic     valid;
    logic     ready;
    t_reg_idx index;
    logic     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/bech32_checksum_engine_unit.sv @@
`default_nettype none
// the first data symbol or finish after a prefix is held as pending while the prefix walk
// feeds a zero and the stored characters' low symbols; then the pending item is processed
// finish: create mode feeds six zero symbols then sends 6 beats, verify mode sends 1 beat
// throughput: one item per cycle while no walk, padding or output is in progress
// synchronous active-low reset returns the residue to one and clears counts, phase, overflow and config bits;
// the prefix store and the result registers are not cleared
// ----------------------------------------------------------------------------
// bech32_checksum_engine_unit
// bech32 / bech32m polymod checksum create and verify engine
// ----------------------------------------------------------------------------
module bech32_checksum_engine_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    b32c_in_if.sink       i_in,
    b32c_out_if.source    o_out,
    b32c_cfg_if.sink      i_cfg
);
    import b32c_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    b32c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_out_last  (o_out.last),
        .o_cmd       (cmd)
    );

    b32c_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_in_opcode       (i_in.opcode),
        .i_in_value        (i_in.value),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .o_sts             (sts),
        .o_symbol          (o_out.symbol),
        .o_valid_res       (o_out.valid_res),
        .o_prefix_overflow (o_out.prefix_overflow)
    );

endmodule
`default_nettype wire

@@ sv/b32c_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_ctrl
// controller: sequences item handling, prefix walk, zero padding and output
// ----------------------------------------------------------------------------
module b32c_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire b32c_pkg::t_opcode i_in_opcode,
    input  wire logic            i_out_ready,
    input  wire b32c_pkg::t_sts  i_sts,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output logic                 o_out_last,
    output b32c_pkg::t_cmd       o_cmd
);
    import b32c_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_RESUME = 5'b00100,
        S_PAD    = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [BEAT_W-1:0]   r_pad, n_pad;
    logic [BEAT_W-1:0]   r_beat, n_beat;
    logic                start_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= '0;
            r_beat  <= '0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_beat  <= n_beat;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pad        = r_pad;
        n_beat       = r_beat;
        o_cmd        = '0;
        o_cmd.feed_sel = FEED_ZERO;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_out_last   = 1'b0;
        start_finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_opcode)
                        OP_PREFIX: begin
                            if (!i_sts.data_phase) begin
                                o_cmd.feed_en  = 1'b1;
                                o_cmd.feed_sel = FEED_IN_HI;
                                o_cmd.store_en = 1'b1;
                            end
                        end
                        OP_DATA: begin
                            if (i_sts.data_phase) begin
                                o_cmd.feed_en  = 1'b1;
                                o_cmd.feed_sel = FEED_IN_LO;
                            end else begin
                                o_cmd.pend_latch = 1'b1;
                                o_cmd.walk_clr   = 1'b1;
                                n_state          = S_WALK;
                            end
                        end
                        OP_FINISH: begin
                            if (i_sts.data_phase) begin
                                start_finish = 1'b1;
                            end else begin
                                o_cmd.pend_latch = 1'b1;
                                o_cmd.walk_clr   = 1'b1;
                                n_state          = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.feed_en   = 1'b1;
                o_cmd.feed_sel  = FEED_WALK;
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done) begin
                    o_cmd.phase_set = 1'b1;
                    n_state         = S_RESUME;
                end
            end
            S_RESUME: begin
                if (i_sts.pend_finish) begin
                    start_finish = 1'b1;
                end else begin
                    o_cmd.feed_en  = 1'b1;
                    o_cmd.feed_sel = FEED_PEND_LO;
                    n_state        = S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.feed_en  = 1'b1;
                o_cmd.feed_sel = FEED_ZERO;
                if (r_pad == LAST_BEAT) begin
                    o_cmd.chk_load = 1'b1;
                    n_beat         = '0;
                    n_state        = S_EMIT;
                end else begin
                    n_pad = r_pad + 1'b1;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_out_last  = (r_beat == LAST_BEAT);
                if (i_out_ready) begin
                    if (r_beat == LAST_BEAT) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.chk_shift = 1'b1;
                        n_beat          = r_beat + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // verify mode gives one beat, create mode pads six zeros first
        if (start_finish) begin
            if (i_sts.verify_mode) begin
                o_cmd.ver_load = 1'b1;
                n_beat         = LAST_BEAT;
                n_state        = S_EMIT;
            end else begin
                n_pad   = '0;
                n_state = S_PAD;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/b32c_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b32c_dp
// datapath: polymod residue, prefix store, counters and result registers
// ----------------------------------------------------------------------------
module b32c_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire b32c_pkg::t_cmd   i_cmd,
    input  wire b32c_pkg::t_opcode i_in_opcode,
    input  wire b32c_pkg::t_value i_in_value,
    input  wire logic             i_cfg_we,
    input  wire b32c_pkg::t_reg_idx i_cfg_index,
    input  wire logic             i_cfg_data,
    output b32c_pkg::t_sts        o_sts,
    output b32c_pkg::t_sym        o_symbol,
    output logic                  o_valid_res,
    output logic                  o_prefix_overflow
);
    import b32c_pkg::*;

    t_value             mem [0:PREFIX_DEPTH-1];
    t_value             r_rdata;
    t_res               r_residue;
    t_res               n_residue;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_walk;
    logic               r_phase;
    logic               r_ovf;
    logic               r_use_m;
    logic               r_verify;
    t_opcode            r_pend_op;
    t_value             r_pend_val;
    t_res               r_chk;
    logic               r_vres;
    t_sym               feed_sym;
    t_res               target;
    logic               store_room;

    assign target     = r_use_m ? BECH32M_FINAL : BECH32_FINAL;
    assign store_room = (r_count < CNT_W'(PREFIX_DEPTH));

    always_comb begin
        case (i_cmd.feed_sel)
            FEED_ZERO:    feed_sym = '0;
            FEED_IN_HI:   feed_sym = SYM_W'(i_in_value[VAL_W-1:SYM_W]);
            FEED_IN_LO:   feed_sym = i_in_value[SYM_W-1:0];
            FEED_WALK:    feed_sym = (r_walk == '0) ? '0 : r_rdata[SYM_W-1:0];
            FEED_PEND_LO: feed_sym = r_pend_val[SYM_W-1:0];
            default:      feed_sym = '0;
        endcase
        n_residue = poly_step(r_residue, feed_sym);
    end

    // prefix store, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_en && store_room) begin
            mem[r_count[ADDR_W-1:0]] <= i_in_value;
        end
        r_rdata <= mem[r_walk[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residue <= BECH32_FINAL;
            r_count   <= '0;
            r_walk    <= '0;
            r_phase   <= 1'b0;
            r_ovf     <= 1'b0;
            r_use_m   <= 1'b0;
            r_verify  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_USE_BECH32M: r_use_m  <= i_cfg_data;
                    REG_VERIFY_MODE: r_verify <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_residue <= BECH32_FINAL;
                r_count   <= '0;
                r_phase   <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                if (i_cmd.feed_en) begin
                    r_residue <= n_residue;
                end
                if (i_cmd.store_en) begin
                    if (store_room) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                if (i_cmd.phase_set) begin
                    r_phase <= 1'b1;
                end
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_step) begin
                r_walk <= r_walk + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_latch) begin
            r_pend_op  <= i_in_opcode;
            r_pend_val <= i_in_value;
        end
        if (i_cmd.chk_load) begin
            r_chk  <= n_residue ^ target;
            r_vres <= 1'b0;
        end else if (i_cmd.ver_load) begin
            r_chk  <= '0;
            r_vres <= (r_residue == target);
        end else if (i_cmd.chk_shift) begin
            r_chk <= {r_chk[RES_W-SYM_W-1:0], {SYM_W{1'b0}}};
        end
    end

    assign o_sts.data_phase  = r_phase;
    assign o_sts.walk_done   = (r_walk == r_count);
    assign o_sts.pend_finish = (r_pend_op == OP_FINISH);
    assign o_sts.verify_mode = r_verify;

    assign o_symbol          = r_chk[RES_W-1:RES_W-SYM_W];
    assign o_valid_res       = r_vres;
    assign o_prefix_overflow = r_ovf;

endmodule
`default_nettype wire
